### design/assert_macros.svh
// Assertion macros used by the key-value table sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### design/kvt_pkg.sv
// Types and constants for the key-value table.
`default_nettype none

package kvt_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int SLOT_W    = KEY_W + 1;   // valid flag above the key
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0]        entry_value;
    } t_request;

    typedef struct packed {
        logic                 found;
        logic [VAL_W-1:0]     read_value;
        logic                 rejected;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic val_we;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

### design/kvt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/kvt_ctrl.sv
// Sequencer: clearing pass, slot scan and write-back for the key-value table.
`default_nettype none

module kvt_ctrl
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_request          i_request,
    output logic              o_busy,
    input  logic [SLOT_W-1:0] i_key_rdata,
    input  logic [VAL_W-1:0]  i_val_rdata,
    output t_mem_ctl          o_mem,
    output logic [IW-1:0]     o_raddr,
    output logic [IW-1:0]     o_waddr,
    output logic [SLOT_W-1:0] o_key_wdata,
    output logic [VAL_W-1:0]  o_val_wdata,
    output logic              o_done,
    output t_result           o_result
);

`include "assert_macros.svh"

    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    t_state         r_state, n_state;
    logic [IW-1:0]  r_idx, n_idx;
    t_request       r_req, n_req;
    logic           r_hit, n_hit;
    logic [IW-1:0]  r_hit_idx, n_hit_idx;
    logic           r_free, n_free;
    logic [IW-1:0]  r_free_idx, n_free_idx;
    logic [VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]  r_count, n_count;

    logic           slot_valid;
    logic           key_match;
    logic           last_slot;

    assign slot_valid = i_key_rdata[SLOT_W-1];
    assign key_match  = slot_valid && (i_key_rdata[KEY_W-1:0] == $unsigned(r_req.lookup_key));
    assign last_slot  = (r_idx == LAST);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (last_slot) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (last_slot) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Index and request capture, scan bookkeeping: first matching slot and lowest free slot
    always_comb begin
        n_idx      = r_idx;
        n_req      = r_req;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_val      = r_val;
        case (r_state)
            ST_CLEAR: begin
                n_idx = last_slot ? '0 : r_idx + IW'(1);
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_req  = i_request;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    n_idx  = '0;
                end
            end
            ST_SCAN: begin
                if (key_match && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                    n_val     = i_val_rdata;
                end
                if (!slot_valid && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                n_idx = last_slot ? '0 : r_idx + IW'(1);
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // Outputs: memory control, write-back, result and next entry count
    always_comb begin
        o_mem       = '0;
        o_raddr     = r_idx + IW'(1);
        o_waddr     = r_idx;
        o_key_wdata = '0;
        o_val_wdata = r_req.entry_value;
        o_done      = 1'b0;
        o_result    = '0;
        n_count     = r_count;
        case (r_state)
            ST_CLEAR: begin
                o_mem.key_we = 1'b1;
            end
            ST_IDLE: begin
                o_mem.rd_en = i_start;
                o_raddr     = '0;
            end
            ST_SCAN: begin
                o_mem.rd_en = !last_slot;
            end
            ST_WRITE: begin
                o_done = 1'b1;
                case (r_req.action)
                    ACT_INSERT: begin
                        if (r_hit) begin
                            o_mem.val_we = 1'b1;
                            o_waddr      = r_hit_idx;
                        end else if (r_free) begin
                            o_mem.key_we = 1'b1;
                            o_mem.val_we = 1'b1;
                            o_waddr      = r_free_idx;
                            o_key_wdata  = {1'b1, r_req.lookup_key};
                            n_count      = r_count + CW'(1);
                        end else begin
                            o_result.rejected = 1'b1;
                        end
                    end
                    ACT_LOOKUP: begin
                        o_result.found      = r_hit;
                        o_result.read_value = r_hit ? r_val : '0;
                    end
                    ACT_REMOVE: begin
                        if (r_hit) begin
                            o_result.found = 1'b1;
                            o_mem.key_we   = 1'b1;
                            o_waddr        = r_hit_idx;
                            o_key_wdata    = {1'b0, r_req.lookup_key};
                            if (r_count != '0) n_count = r_count - CW'(1);
                        end
                    end
                    default: begin
                        o_result.found = 1'b0;
                    end
                endcase
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
        o_result.entry_count = CNT_OUT_W'(n_count);
    end

    assign o_busy    = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_count <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_hit   <= n_hit;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_val      <= n_val;
    end

    `ASSERT_NEXT(a_scan_ends_in_write, i_clk, i_rst_n, (r_state == ST_SCAN) && last_slot, r_state == ST_WRITE)
    `ASSERT_NEXT(a_write_returns_idle, i_clk, i_rst_n, r_state == ST_WRITE, r_state == ST_IDLE)
    `ASSERT_IMPLIES(a_reject_only_full, i_clk, i_rst_n, o_done && o_result.rejected, r_count == CW'(CAPACITY))
    `ASSERT_IMPLIES(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))

endmodule

`default_nettype wire

### design/key_value_table.sv
// Top level of the key-value table: key and value RAMs, sequencer, result register.
// A request is captured, then the scan reads one slot per cycle from the key and value RAMs,
// then one write-back follows and the result is registered. A new request is taken only in
// idle, while busy is low.
// Reset: busy stays high for a clearing pass that invalidates every slot.
// The result strobe o_done lasts one cycle; the receiver cannot stall it.
`default_nettype none

module key_value_table
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_request,
    output logic     busy,
    output logic     o_done,
    output t_result  o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_mem_ctl          mem_ctl;
    logic [IW-1:0]     raddr;
    logic [IW-1:0]     waddr;
    logic [SLOT_W-1:0] key_wdata;
    logic [SLOT_W-1:0] key_rdata;
    logic [VAL_W-1:0]  val_wdata;
    logic [VAL_W-1:0]  val_rdata;
    logic              done;
    t_result           result;

    logic              r_done;
    t_result           r_result;

    kvt_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_request  (i_request),
        .o_busy     (busy),
        .i_key_rdata(key_rdata),
        .i_val_rdata(val_rdata),
        .o_mem      (mem_ctl),
        .o_raddr    (raddr),
        .o_waddr    (waddr),
        .o_key_wdata(key_wdata),
        .o_val_wdata(val_wdata),
        .o_done     (done),
        .o_result   (result)
    );

    kvt_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (mem_ctl.key_we),
        .i_waddr(waddr),
        .i_wdata(key_wdata),
        .i_re   (mem_ctl.rd_en),
        .i_raddr(raddr),
        .o_rdata(key_rdata)
    );

    kvt_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (mem_ctl.val_we),
        .i_waddr(waddr),
        .i_wdata(val_wdata),
        .i_re   (mem_ctl.rd_en),
        .i_raddr(raddr),
        .o_rdata(val_rdata)
    );

    // Register the done strobe, and hold the result until the next write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_result <= result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
